>>> rtl/drrip_pkg.sv
// Shared types and constants for the DRRIP replacement engine.
// No dependencies; only drrip_dead_block_replacement refers to this package.
package drrip_pkg;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRAP,
      ST_READ,
      ST_EVAL,
      ST_DECAY_RD,
      ST_DECAY_WR
   } state_type;

   // Request operation codes.
   localparam logic OP_VICTIM = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_LEADER = 2'd0;
   localparam logic [1:0] REG_NEAR   = 2'd1;
   localparam logic [1:0] REG_FAR    = 2'd2;
   localparam logic [1:0] REG_DECAY  = 2'd3;

   // Register reset values.
   localparam logic [10:0] LEADER_RESET = 11'd64;
   localparam logic [1:0]  NEAR_RESET   = 2'd1;
   localparam logic [1:0]  FAR_RESET    = 2'd2;
   localparam logic [15:0] DECAY_RESET  = 16'd4096;

   // Width used for set arithmetic; holds any set count in range.
   localparam int SET_CALC_WIDTH = 18;

endpackage

>>> rtl/drrip_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing; used by the top level.
interface drrip_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [10:0] set_index;
   logic [3:0]  way_index;
   logic        was_hit;
   modport source (output valid, operation, set_index, way_index, was_hit, input ready);
   modport sink (input valid, operation, set_index, way_index, was_hit, output ready);
endinterface

interface drrip_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] victim_way;
   logic       dead_victim;
   logic [1:0] written_value;
   modport source (output valid, victim_way, dead_victim, written_value, input ready);
   modport sink (input valid, victim_way, dead_victim, written_value, output ready);
endinterface

>>> rtl/drrip_row_search.sv
// Victim search and aging over one set row.
// Depends on nothing; instanced by drrip_dead_block_replacement.
module drrip_row_search #(
   parameter int WAYS        = 16,
   parameter int RRPV_WIDTH  = 2,
   parameter int REUSE_WIDTH = 2,
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  logic [WAYS-1:0][RRPV_WIDTH-1:0]  rv_in,
   input  logic [WAYS-1:0][REUSE_WIDTH-1:0] ru_in,
   output logic [WW-1:0]                    victim,
   output logic                             dead,
   output logic [WAYS-1:0][RRPV_WIDTH-1:0]  rv_aged
);
   localparam logic [RRPV_WIDTH-1:0] RV_MAX = '1;

   logic [RRPV_WIDTH-1:0] top;
   logic [RRPV_WIDTH-1:0] step;
   logic [WW-1:0]         dead_way;
   logic [WW-1:0]         any_way;
   logic                  dead_found;

   // Largest value in the row; aging lifts it to the maximum.
   always_comb begin
      top = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (rv_in[w] > top) top = rv_in[w];
      end
      step = RV_MAX - top;
      for (int w = 0; w < WAYS; w++) begin
         rv_aged[w] = rv_in[w] + step;
      end
   end

   // After aging the maximal ways are those equal to top; one with zero reuse wins, then lowest index.
   always_comb begin
      dead_way   = '0;
      any_way    = '0;
      dead_found = 1'b0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (rv_in[w] == top) begin
            any_way = WW'(w);
            if (ru_in[w] == '0) begin
               dead_way   = WW'(w);
               dead_found = 1'b1;
            end
         end
      end
      victim = dead_found ? dead_way : any_way;
      dead   = dead_found;
   end
endmodule

>>> rtl/drrip_dead_block_replacement.sv
// Top level of the DRRIP replacement engine with dead-block hint.
// Depends on drrip_pkg, drrip_if and drrip_row_search.
// A response beat follows its request beat through the wrap check, row read and
// evaluate states; each subtract of a set index at or above SETS adds a wrap step.
// A request is taken only after the previous response beat has left, so a new
// item is not taken before the last is through. A decaying update then sweeps all
// rows, reading and writing each, not ready meanwhile. After reset a clearing pass
// initializes every row; no request is taken during it, configuration writes are.
module drrip_dead_block_replacement #(
   parameter int SETS           = 2048,
   parameter int WAYS           = 16,
   parameter int RRPV_WIDTH     = 2,
   parameter int REUSE_WIDTH    = 2,
   parameter int SELECTOR_WIDTH = 10
) (
   input  logic        clock,
   input  logic        reset,
   drrip_req_if.sink   req_bus,
   drrip_rsp_if.source rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int CW = drrip_pkg::SET_CALC_WIDTH;
   localparam logic [CW-1:0] SETS_C = CW'(SETS);
   localparam logic [RRPV_WIDTH-1:0] RV_MAX = '1;
   localparam logic [REUSE_WIDTH-1:0] RU_MAX = '1;
   localparam logic [SELECTOR_WIDTH-1:0] SEL_MAX = '1;
   localparam logic [SELECTOR_WIDTH-1:0] SEL_HALF = SEL_MAX >> 1;
   localparam logic [3:0] RV_MAX4 = 4'(RV_MAX);

   typedef logic [WAYS-1:0][RRPV_WIDTH-1:0]  rv_row_type;
   typedef logic [WAYS-1:0][REUSE_WIDTH-1:0] ru_row_type;

   // Row memories, one row per set.
   rv_row_type rv_mem [SETS];
   ru_row_type ru_mem [SETS];

   drrip_pkg::state_type state_ff, state_in;

   logic [10:0] leader_ff, leader_in;
   logic [1:0]  near_ff, near_in;
   logic [1:0]  far_ff, far_in;
   logic [15:0] period_ff, period_in;
   logic [SELECTOR_WIDTH-1:0] sel_ff, sel_in;
   logic [15:0] tally_ff, tally_in;
   logic [SW-1:0] sweep_ff, sweep_in;

   logic        op_ff, op_in;
   logic [10:0] set_ff, set_in;
   logic [3:0]  way_ff, way_in;
   logic        hit_ff, hit_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] rsp_way_ff, rsp_way_in;
   logic       rsp_dead_ff, rsp_dead_in;
   logic [1:0] rsp_val_ff, rsp_val_in;

   rv_row_type rd_rv_ff, rv_aged, wr_rv;
   ru_row_type rd_ru_ff, wr_ru;
   logic       rd_en, wr_en;
   logic [SW-1:0] rd_addr, wr_addr;

   logic [WW-1:0] victim;
   logic          dead;

   logic [CW-1:0] set_w;
   logic [SW-1:0] set_addr;
   logic          lead_s, lead_b, in_range;
   logic [5:0]    way_w;
   logic [WW-1:0] way_idx;
   logic [RRPV_WIDTH-1:0] near_val, far_val, ins_val;
   logic [15:0]   tally_next;
   logic          do_decay;
   logic          cfg_wr;

   drrip_row_search #(
      .WAYS(WAYS),
      .RRPV_WIDTH(RRPV_WIDTH),
      .REUSE_WIDTH(REUSE_WIDTH)
   ) u_search (
      .rv_in(rd_rv_ff),
      .ru_in(rd_ru_ff),
      .victim(victim),
      .dead(dead),
      .rv_aged(rv_aged)
   );

   // Configuration port: always ready, reads are a simple mux.
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      leader_in = leader_ff;
      near_in   = near_ff;
      far_in    = far_ff;
      period_in = period_ff;
      if (cfg_wr) begin
         case (paddr[3:2])
            drrip_pkg::REG_LEADER: leader_in = pwdata[10:0];
            drrip_pkg::REG_NEAR:   near_in   = pwdata[1:0];
            drrip_pkg::REG_FAR:    far_in    = pwdata[1:0];
            drrip_pkg::REG_DECAY:  period_in = pwdata[15:0];
            default: ;
         endcase
      end
      case (paddr[3:2])
         drrip_pkg::REG_LEADER: prdata = {21'd0, leader_ff};
         drrip_pkg::REG_NEAR:   prdata = {30'd0, near_ff};
         drrip_pkg::REG_FAR:    prdata = {30'd0, far_ff};
         drrip_pkg::REG_DECAY:  prdata = {16'd0, period_ff};
         default:               prdata = 32'd0;
      endcase
   end

   // Set classification and insertion value for the current item.
   always_comb begin
      set_w    = CW'(set_ff);
      set_addr = set_w[SW-1:0];
      lead_s   = set_w < CW'(leader_ff);
      lead_b   = !lead_s && (leader_ff != 11'd0) && ((SETS_C - set_w) <= CW'(leader_ff));
      way_w    = 6'(way_ff);
      in_range = way_w < 6'(WAYS);
      way_idx  = way_w[WW-1:0];
      near_val = (4'(near_ff) > RV_MAX4) ? RV_MAX : RRPV_WIDTH'(near_ff);
      far_val  = (4'(far_ff) > RV_MAX4) ? RV_MAX : RRPV_WIDTH'(far_ff);
      if (lead_s) ins_val = near_val;
      else if (lead_b) ins_val = far_val;
      else if (sel_ff >= SEL_HALF) ins_val = near_val;
      else ins_val = far_val;
      tally_next = tally_ff + 16'd1;
      do_decay   = (period_ff != 16'd0) && (tally_next >= period_ff);
   end

   // Sequencer: next state, memory control and response.
   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      tally_in     = tally_ff;
      sweep_in     = sweep_ff;
      op_in        = op_ff;
      set_in       = set_ff;
      way_in       = way_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_way_in   = rsp_way_ff;
      rsp_dead_in  = rsp_dead_ff;
      rsp_val_in   = rsp_val_ff;
      rd_en        = 1'b0;
      rd_addr      = set_addr;
      wr_en        = 1'b0;
      wr_addr      = set_addr;
      wr_rv        = rd_rv_ff;
      wr_ru        = rd_ru_ff;
      req_bus.ready = 1'b0;

      case (state_ff)
         drrip_pkg::ST_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_rv    = {WAYS{RV_MAX}};
            wr_ru    = '0;
            sweep_in = sweep_ff + 1'b1;
            if (CW'(sweep_ff) == SETS_C - 1'b1) begin
               sweep_in = '0;
               state_in = drrip_pkg::ST_IDLE;
            end
         end
         drrip_pkg::ST_IDLE: begin
            req_bus.ready = !rsp_valid_ff;
            if (req_bus.valid && !rsp_valid_ff) begin
               op_in    = req_bus.operation;
               set_in   = req_bus.set_index;
               way_in   = req_bus.way_index;
               hit_in   = req_bus.was_hit;
               state_in = drrip_pkg::ST_WRAP;
            end
         end
         drrip_pkg::ST_WRAP: begin
            // Reduce the set index below SETS one subtraction a cycle.
            if (set_w >= SETS_C) begin
               set_in = 11'(set_w - SETS_C);
            end else begin
               state_in = drrip_pkg::ST_READ;
            end
         end
         drrip_pkg::ST_READ: begin
            rd_en    = 1'b1;
            state_in = drrip_pkg::ST_EVAL;
         end
         drrip_pkg::ST_EVAL: begin
            rsp_valid_in = 1'b1;
            state_in     = drrip_pkg::ST_IDLE;
            if (op_ff == drrip_pkg::OP_VICTIM) begin
               wr_en       = 1'b1;
               wr_rv       = rv_aged;
               rsp_way_in  = 4'(victim);
               rsp_dead_in = dead;
               rsp_val_in  = 2'd0;
            end else begin
               wr_en = in_range;
               if (hit_ff) begin
                  wr_rv[way_idx] = '0;
                  if (rd_ru_ff[way_idx] != RU_MAX) wr_ru[way_idx] = rd_ru_ff[way_idx] + 1'b1;
                  if (lead_s && sel_ff != SEL_MAX) sel_in = sel_ff + 1'b1;
                  if (lead_b && sel_ff != '0) sel_in = sel_ff - 1'b1;
                  rsp_val_in = 2'd0;
               end else begin
                  wr_rv[way_idx] = ins_val;
                  wr_ru[way_idx] = '0;
                  rsp_val_in     = 2'(ins_val);
               end
               rsp_way_in  = 4'd0;
               rsp_dead_in = 1'b0;
               if (do_decay) begin
                  tally_in = 16'd0;
                  sweep_in = '0;
                  state_in = drrip_pkg::ST_DECAY_RD;
               end else begin
                  tally_in = tally_next;
               end
            end
         end
         drrip_pkg::ST_DECAY_RD: begin
            rd_en    = 1'b1;
            rd_addr  = sweep_ff;
            state_in = drrip_pkg::ST_DECAY_WR;
         end
         drrip_pkg::ST_DECAY_WR: begin
            // Decrement every nonzero reuse counter in the row just read.
            wr_en   = 1'b1;
            wr_addr = sweep_ff;
            for (int w = 0; w < WAYS; w++) begin
               if (rd_ru_ff[w] != '0) wr_ru[w] = rd_ru_ff[w] - 1'b1;
            end
            sweep_in = sweep_ff + 1'b1;
            state_in = drrip_pkg::ST_DECAY_RD;
            if (CW'(sweep_ff) == SETS_C - 1'b1) begin
               sweep_in = '0;
               state_in = drrip_pkg::ST_IDLE;
            end
         end
         default: state_in = drrip_pkg::ST_IDLE;
      endcase
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.victim_way    = rsp_way_ff;
   assign rsp_bus.dead_victim   = rsp_dead_ff;
   assign rsp_bus.written_value = rsp_val_ff;

   // Row memories with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rv_mem[wr_addr] <= wr_rv;
         ru_mem[wr_addr] <= wr_ru;
      end
      if (rd_en) begin
         rd_rv_ff <= rv_mem[rd_addr];
         rd_ru_ff <= ru_mem[rd_addr];
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drrip_pkg::ST_CLEAR;
         leader_ff    <= drrip_pkg::LEADER_RESET;
         near_ff      <= drrip_pkg::NEAR_RESET;
         far_ff       <= drrip_pkg::FAR_RESET;
         period_ff    <= drrip_pkg::DECAY_RESET;
         sel_ff       <= SEL_HALF;
         tally_ff     <= 16'd0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         leader_ff    <= leader_in;
         near_ff      <= near_in;
         far_ff       <= far_in;
         period_ff    <= period_in;
         sel_ff       <= sel_in;
         tally_ff     <= tally_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and response payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      set_ff      <= set_in;
      way_ff      <= way_in;
      hit_ff      <= hit_in;
      rsp_way_ff  <= rsp_way_in;
      rsp_dead_ff <= rsp_dead_in;
      rsp_val_ff  <= rsp_val_in;
   end
endmodule
